[design/ole_pkg.sv]
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types and constants of the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int CAPACITY = 256;
  localparam int SLOT_W   = $clog2(CAPACITY);
  localparam int CNT_W    = SLOT_W + 1;
  localparam int VALUE_W  = 32;

  localparam logic [2:0] OP_GET          = 3'd0;
  localparam logic [2:0] OP_SET          = 3'd1;
  localparam logic [2:0] OP_INSERT_AT    = 3'd2;
  localparam logic [2:0] OP_REMOVE_AT    = 3'd3;
  localparam logic [2:0] OP_REMOVE_VALUE = 3'd4;
  localparam logic [2:0] OP_FIND         = 3'd5;
  localparam logic [2:0] OP_CLEAR        = 3'd6;
  localparam logic [2:0] OP_NONE         = 3'd7;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_RANGE     = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL      = 2'd3;

  typedef struct packed {
    logic [2:0]         opcode;
    logic [CNT_W-1:0]   position;
    logic signed [31:0] item_value;
  } cmd_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] read_value;
    logic [CNT_W-1:0]   count_after;
  } rsp_t;

  typedef struct packed {
    logic [SLOT_W-1:0]  rd_addr;
    logic [SLOT_W-1:0]  stk_rd_addr;
    logic               val_we;
    logic [SLOT_W-1:0]  val_waddr;
    logic [VALUE_W-1:0] val_wdata;
    logic               lnk_we;
    logic [SLOT_W-1:0]  lnk_waddr;
    logic [SLOT_W-1:0]  lnk_wdata;
    logic               stk_we;
    logic [SLOT_W-1:0]  stk_waddr;
    logic [SLOT_W-1:0]  stk_wdata;
  } store_req_t;

  typedef struct packed {
    logic [VALUE_W-1:0] val;
    logic [SLOT_W-1:0]  lnk;
    logic [SLOT_W-1:0]  stk;
  } store_rsp_t;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ALLOC = 5'b00010,
    S_WALK  = 5'b00100,
    S_LINK2 = 5'b01000,
    S_DONE  = 5'b10000
  } state_t;

endpackage

[design/ole_store.sv]
// ----------------------------------------------------------------------------
// ole_store
// Slot value, slot link and recycled-slot stack memories, registered read.
// ----------------------------------------------------------------------------
module ole_store (
  input  logic                clk,
  input  ole_pkg::store_req_t req,
  output ole_pkg::store_rsp_t rsp
);

  logic [ole_pkg::VALUE_W-1:0] values [ole_pkg::CAPACITY];
  logic [ole_pkg::SLOT_W-1:0]  links  [ole_pkg::CAPACITY];
  logic [ole_pkg::SLOT_W-1:0]  stack  [ole_pkg::CAPACITY];

  always_ff @(posedge clk) begin
    if (req.val_we) begin
      values[req.val_waddr] <= req.val_wdata;
    end
    if (req.lnk_we) begin
      links[req.lnk_waddr] <= req.lnk_wdata;
    end
    if (req.stk_we) begin
      stack[req.stk_waddr] <= req.stk_wdata;
    end
    rsp.val <= values[req.rd_addr];
    rsp.lnk <= links[req.rd_addr];
    rsp.stk <= stack[req.stk_rd_addr];
  end

endmodule

[design/ole_ctrl.sv]
// ----------------------------------------------------------------------------
// ole_ctrl
// Command sequencer: checks, slot allocation, link walk and relinking.
// ----------------------------------------------------------------------------
module ole_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_accept,
  input  ole_pkg::cmd_t       cmd,
  output logic                idle,
  output logic                res_valid,
  input  logic                res_take,
  output ole_pkg::rsp_t       res,
  output ole_pkg::store_req_t req,
  input  ole_pkg::store_rsp_t rsp
);

  ole_pkg::state_t state, state_next;
  logic [2:0]                   op, op_next;
  logic [ole_pkg::CNT_W-1:0]    pos, pos_next;
  logic [ole_pkg::VALUE_W-1:0]  val, val_next;
  logic [ole_pkg::SLOT_W-1:0]   first, first_next, last, last_next;
  logic [ole_pkg::SLOT_W-1:0]   cur, cur_next, prev, prev_next, slot, slot_next;
  logic [ole_pkg::CNT_W-1:0]    count, count_next, stk_cnt, stk_cnt_next;
  logic [ole_pkg::CNT_W-1:0]    fresh, fresh_next, idx, idx_next;
  logic [1:0]                   status, status_next;
  logic [31:0]                  rval, rval_next;
  logic [ole_pkg::SLOT_W-1:0]   new_slot;
  logic                         hit, value_op;

  assign idle      = (state == ole_pkg::S_IDLE);
  assign res_valid = (state == ole_pkg::S_DONE);
  assign res.status      = status;
  assign res.read_value  = rval;
  assign res.count_after = count;

  assign new_slot = (stk_cnt != '0) ? rsp.stk : fresh[ole_pkg::SLOT_W-1:0];
  assign value_op = (op == ole_pkg::OP_REMOVE_VALUE) || (op == ole_pkg::OP_FIND);
  assign hit      = value_op ? (rsp.val == val) : (idx == pos);

  always_comb begin
    state_next   = state;
    op_next      = op;
    pos_next     = pos;
    val_next     = val;
    first_next   = first;
    last_next    = last;
    cur_next     = cur;
    prev_next    = prev;
    slot_next    = slot;
    count_next   = count;
    stk_cnt_next = stk_cnt;
    fresh_next   = fresh;
    idx_next     = idx;
    status_next  = status;
    rval_next    = rval;
    req             = '0;
    req.rd_addr     = first;
    req.stk_rd_addr = ole_pkg::SLOT_W'(stk_cnt - 1'b1);

    unique case (state)
      ole_pkg::S_IDLE: begin
        if (cmd_accept) begin
          op_next     = cmd.opcode;
          pos_next    = cmd.position;
          val_next    = cmd.item_value;
          status_next = ole_pkg::ST_OK;
          rval_next   = '1;
          cur_next    = first;
          prev_next   = first;
          idx_next    = '0;
          state_next  = ole_pkg::S_DONE;
          unique case (cmd.opcode)
            ole_pkg::OP_GET, ole_pkg::OP_SET, ole_pkg::OP_REMOVE_AT: begin
              if (cmd.position >= count) status_next = ole_pkg::ST_RANGE;
              else state_next = ole_pkg::S_WALK;
            end
            ole_pkg::OP_INSERT_AT: begin
              priority if (cmd.position > count) status_next = ole_pkg::ST_RANGE;
              else if (count == ole_pkg::CNT_W'(ole_pkg::CAPACITY))
                status_next = ole_pkg::ST_FULL;
              else state_next = ole_pkg::S_ALLOC;
            end
            ole_pkg::OP_REMOVE_VALUE, ole_pkg::OP_FIND: begin
              priority if (count == '0) begin
                status_next = (cmd.opcode == ole_pkg::OP_REMOVE_VALUE) ?
                              ole_pkg::ST_RANGE : ole_pkg::ST_NOT_FOUND;
              end else state_next = ole_pkg::S_WALK;
            end
            ole_pkg::OP_CLEAR: begin
              first_next   = '0;
              last_next    = '0;
              count_next   = '0;
              stk_cnt_next = '0;
              fresh_next   = '0;
            end
            default: status_next = ole_pkg::ST_RANGE;
          endcase
        end
      end

      ole_pkg::S_ALLOC: begin
        // take a recycled slot first, else the next never-used one
        if (stk_cnt != '0) stk_cnt_next = stk_cnt - 1'b1;
        else fresh_next = fresh + 1'b1;
        slot_next     = new_slot;
        req.val_we    = 1'b1;
        req.val_waddr = new_slot;
        req.val_wdata = val;
        priority if (pos == '0) begin
          req.lnk_we    = 1'b1;
          req.lnk_waddr = new_slot;
          req.lnk_wdata = first;
          first_next    = new_slot;
          if (count == '0) last_next = new_slot;
          count_next    = count + 1'b1;
          state_next    = ole_pkg::S_DONE;
        end else if (pos == count) begin
          req.lnk_we    = 1'b1;
          req.lnk_waddr = last;
          req.lnk_wdata = new_slot;
          last_next     = new_slot;
          count_next    = count + 1'b1;
          state_next    = ole_pkg::S_DONE;
        end else begin
          state_next    = ole_pkg::S_WALK;
        end
      end

      ole_pkg::S_WALK: begin
        if (hit) begin
          state_next = ole_pkg::S_DONE;
          unique case (op)
            ole_pkg::OP_GET: rval_next = rsp.val;
            ole_pkg::OP_SET: begin
              req.val_we    = 1'b1;
              req.val_waddr = cur;
              req.val_wdata = val;
            end
            ole_pkg::OP_INSERT_AT: begin
              req.lnk_we    = 1'b1;
              req.lnk_waddr = slot;
              req.lnk_wdata = cur;
              state_next    = ole_pkg::S_LINK2;
            end
            ole_pkg::OP_FIND: rval_next = 32'(idx);
            default: begin
              // unlink cur and push it on the recycled stack
              if (idx == '0) begin
                first_next = (count == 1) ? '0 : rsp.lnk;
                if (count == 1) last_next = '0;
              end else begin
                req.lnk_we    = 1'b1;
                req.lnk_waddr = prev;
                req.lnk_wdata = rsp.lnk;
                if (cur == last) last_next = prev;
              end
              req.stk_we    = 1'b1;
              req.stk_waddr = stk_cnt[ole_pkg::SLOT_W-1:0];
              req.stk_wdata = cur;
              stk_cnt_next  = stk_cnt + 1'b1;
              count_next    = count - 1'b1;
            end
          endcase
        end else if (value_op && (idx == count - 1'b1)) begin
          status_next = ole_pkg::ST_NOT_FOUND;
          state_next  = ole_pkg::S_DONE;
        end else begin
          // advance one slot
          req.rd_addr = rsp.lnk;
          prev_next   = cur;
          cur_next    = rsp.lnk;
          idx_next    = idx + 1'b1;
        end
      end

      ole_pkg::S_LINK2: begin
        req.lnk_we    = 1'b1;
        req.lnk_waddr = prev;
        req.lnk_wdata = slot;
        count_next    = count + 1'b1;
        state_next    = ole_pkg::S_DONE;
      end

      ole_pkg::S_DONE: begin
        if (res_take) state_next = ole_pkg::S_IDLE;
      end

      default: state_next = ole_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ole_pkg::S_IDLE;
      first   <= '0;
      last    <= '0;
      count   <= '0;
      stk_cnt <= '0;
      fresh   <= '0;
    end else begin
      state   <= state_next;
      first   <= first_next;
      last    <= last_next;
      count   <= count_next;
      stk_cnt <= stk_cnt_next;
      fresh   <= fresh_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    pos    <= pos_next;
    val    <= val_next;
    cur    <= cur_next;
    prev   <= prev_next;
    slot   <= slot_next;
    idx    <= idx_next;
    status <= status_next;
    rval   <= rval_next;
  end

endmodule

[design/ordered_list_engine.sv]
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of up to 256 signed 32-bit values in linked memory slots.
// ----------------------------------------------------------------------------
// Usage:
//   Commands arrive on cmd (cmd_valid / cmd_stall); each gives exactly one
//   response beat on rsp (rsp_valid / rsp_stall) with status, value and the
//   element count after the command.
//   Commands rejected by a range or full check, and clear, go from idle
//   straight to the done state, which hands them to the response register.
//   Position and value commands walk the slot links through the link
//   memory, one slot per cycle. The walk, bound by the registered read of
//   the link memory, sets how long a command takes.
//   Only one command is in work at a time; cmd_stall is high while it is.
//   A finished response waits in the output register while the next command
//   is taken; if that register is still full, the sequencer holds its result.
//   Reset empties the list at once; no memory sweep is needed since unused
//   slots are handed out from a counter.
// ----------------------------------------------------------------------------
module ordered_list_engine (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  ole_pkg::cmd_t cmd,
  output logic          rsp_valid,
  input  logic          rsp_stall,
  output ole_pkg::rsp_t rsp
);

  ole_pkg::store_req_t req;
  ole_pkg::store_rsp_t mem;
  ole_pkg::rsp_t       res;
  logic                idle, res_valid, res_take;

  assign cmd_stall = !idle;
  assign res_take  = res_valid && (!rsp_valid || !rsp_stall);

  ole_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .cmd_accept (cmd_valid && idle),
    .cmd        (cmd),
    .idle       (idle),
    .res_valid  (res_valid),
    .res_take   (res_take),
    .res        (res),
    .req        (req),
    .rsp        (mem)
  );

  ole_store u_store (
    .clk (clk),
    .req (req),
    .rsp (mem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_take) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      rsp <= res;
    end
  end

endmodule
